@@ sv/ckd_pkg.sv @@
// Shared types, constants and the multiply schedule of the curvature kink detector.
package ckd_pkg;

    localparam int POS_W      = 32;
    localparam int IDX_W      = 16;
    localparam int TIME_W     = 32;
    localparam int THR_W      = 31;
    localparam int LEN_W      = 31;
    localparam int CFG_W      = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int IN_TDATA_W  = 80;
    localparam int OUT_TDATA_W = 72;

    // Long-number engine: little-endian limbs.
    localparam int LIMB_W  = 32;
    localparam int Z_LIMBS = 16;
    localparam int Y_LIMBS = 8;
    localparam int ZB      = Z_LIMBS * LIMB_W;
    localparam int YB      = Y_LIMBS * LIMB_W;
    localparam int ZI_W    = $clog2(Z_LIMBS);
    localparam int YI_W    = $clog2(Y_LIMBS);

    localparam int QUO_W     = 16;
    localparam int REL_W     = QUO_W + 1;
    localparam int DIV_CNT_W = $clog2(QUO_W);

    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] LAST_STEP = 4'd12;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_THRESH    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOX_MIN   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOX_LEN   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_TIME = 2'd3;

    // Operand selection of the shared 32x32 multiplier.
    localparam logic [1:0] MS_MAC = 2'd0;
    localparam logic [1:0] MS_AB  = 2'd1;
    localparam logic [1:0] MS_PB  = 2'd2;
    localparam logic [1:0] MS_QA  = 2'd3;

    // Sources of the long multiplicand X.
    localparam logic [1:0] XS_Z   = 2'd0;
    localparam logic [1:0] XS_D   = 2'd1;
    localparam logic [1:0] XS_N   = 2'd2;
    localparam logic [1:0] XS_T16 = 2'd3;

    // Sources of the multiplier Y.
    localparam logic [2:0] YS_D   = 3'd0;
    localparam logic [2:0] YS_N   = 3'd1;
    localparam logic [2:0] YS_ZLO = 3'd2;
    localparam logic [2:0] YS_K   = 3'd3;
    localparam logic [2:0] YS_S   = 3'd4;
    localparam logic [2:0] YS_T16 = 3'd5;
    localparam logic [2:0] YS_M   = 3'd6;
    localparam logic [2:0] YS_AB  = 3'd7;

    typedef struct packed {
        logic [1:0] xsrc;
        logic [2:0] ysrc;
        logic       clear;
        logic       save_k;
        logic       save_l;
        logic [2:0] rows;
    } t_step;

    typedef struct packed {
        logic              accept;
        logic              prep_mul;
        logic [1:0]        mul_sel;
        logic              combine;
        logic              load;
        logic [STEP_W-1:0] step;
        logic              mac;
        logic              first;
        logic [ZI_W-1:0]   i;
        logic [YI_W-1:0]   j;
        logic              div_init;
        logic              div_step;
        logic              load_out;
    } t_cmd;

    typedef struct packed {
        logic eval;
        logic degen;
        logic m_zero;
        logic less;
    } t_sts;

    // Schedule of long multiplications. The first six build
    // L = (D^2 + N^2)^3 * S^2, the rest build R = (16T)^2 * M^2 * AB^4.
    function automatic t_step step_desc(input logic [STEP_W-1:0] step);
        t_step d;
        d = '0;
        unique case (step)
            4'd0:  begin d.xsrc = XS_D;   d.ysrc = YS_D;   d.clear = 1'b1; d.rows = 3'd3; end
            4'd1:  begin d.xsrc = XS_N;   d.ysrc = YS_N;   d.rows = 3'd3; end
            4'd2:  begin
                d.xsrc = XS_Z; d.ysrc = YS_ZLO; d.clear = 1'b1; d.save_k = 1'b1; d.rows = 3'd5;
            end
            4'd3:  begin d.xsrc = XS_Z;   d.ysrc = YS_K;   d.clear = 1'b1; d.rows = 3'd5; end
            4'd4:  begin d.xsrc = XS_Z;   d.ysrc = YS_S;   d.clear = 1'b1; d.rows = 3'd1; end
            4'd5:  begin d.xsrc = XS_Z;   d.ysrc = YS_S;   d.clear = 1'b1; d.rows = 3'd1; end
            4'd6:  begin
                d.xsrc = XS_T16; d.ysrc = YS_T16; d.clear = 1'b1; d.save_l = 1'b1; d.rows = 3'd2;
            end
            4'd7:  begin d.xsrc = XS_Z;   d.ysrc = YS_M;   d.clear = 1'b1; d.rows = 3'd3; end
            4'd8:  begin d.xsrc = XS_Z;   d.ysrc = YS_M;   d.clear = 1'b1; d.rows = 3'd3; end
            4'd9, 4'd10, 4'd11, 4'd12: begin
                d.xsrc = XS_Z; d.ysrc = YS_AB; d.clear = 1'b1; d.rows = 3'd2;
            end
            default: begin d.rows = 3'd1; end
        endcase
        return d;
    endfunction

endpackage

@@ sv/curvature_kink_detector.sv @@
// Top level of the curvature kink detector: sequencer and datapath.
//
// Contour points enter one item at a time; each point that completes a window
// of three is checked exactly for 0 < |R| < radius_threshold, with R the
// three-point radius of curvature, and yields at most one report. A point that
// only fills the window, a window with a zero x step and equal slopes end the
// evaluation early. The time of a full evaluation is set by thirteen long
// multiplications of up to 512 bits, run limb by limb through one 32x32
// multiply-accumulate unit, followed by a restoring divider for the relative x
// position. A new point is taken while a report still waits at the output.
module curvature_kink_detector import ckd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // point_x [31:0], point_z [63:32], point_index [79:64]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // contour_start
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // report_time [31:0], middle_index [47:32], relative_x [64:48], zeros above
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // is_peak
    output logic                   m_tuser,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    ckd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    ckd_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

endmodule

@@ sv/ckd_ctrl.sv @@
// Sequencer of the curvature kink detector: handshakes and command generation.
module ckd_ctrl import ckd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_MAB   = 4'd2;
    localparam logic [3:0] S_MPB   = 4'd3;
    localparam logic [3:0] S_MQA   = 4'd4;
    localparam logic [3:0] S_COMB  = 4'd5;
    localparam logic [3:0] S_CHK   = 4'd6;
    localparam logic [3:0] S_LOAD  = 4'd7;
    localparam logic [3:0] S_MAC   = 4'd8;
    localparam logic [3:0] S_CMP   = 4'd9;
    localparam logic [3:0] S_DIV   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]           r_state, n_state;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [ZI_W-1:0]      r_i, n_i;
    logic [YI_W-1:0]      r_j, n_j;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_out_valid, n_out_valid;
    logic [ZI_W-1:0]      zi;
    t_step                desc;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_i         = r_i;
        n_j         = r_j;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~m_tready;
        desc        = step_desc(r_step);
        zi          = r_i + ZI_W'(r_j);
        o_cmd       = '0;
        o_cmd.mul_sel = MS_MAC;
        o_cmd.step  = r_step;
        o_cmd.i     = r_i;
        o_cmd.j     = r_j;
        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state = S_START;
                end
            end
            S_START: begin
                n_state = (i_sts.eval && !i_sts.degen) ? S_MAB : S_IDLE;
            end
            S_MAB: begin
                o_cmd.prep_mul = 1'b1;
                o_cmd.mul_sel  = MS_AB;
                n_state = S_MPB;
            end
            S_MPB: begin
                o_cmd.prep_mul = 1'b1;
                o_cmd.mul_sel  = MS_PB;
                n_state = S_MQA;
            end
            S_MQA: begin
                o_cmd.prep_mul = 1'b1;
                o_cmd.mul_sel  = MS_QA;
                n_state = S_COMB;
            end
            S_COMB: begin
                o_cmd.combine = 1'b1;
                n_state = S_CHK;
            end
            S_CHK: begin
                // Equal slopes give an infinite radius.
                n_step  = '0;
                n_state = i_sts.m_zero ? S_IDLE : S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_i = '0;
                n_j = '0;
                n_state = S_MAC;
            end
            S_MAC: begin
                o_cmd.mac   = 1'b1;
                o_cmd.first = (r_i == '0);
                if (zi == ZI_W'(Z_LIMBS - 1)) begin
                    if (r_j == desc.rows - 3'd1) begin
                        if (r_step == LAST_STEP) begin
                            n_state = S_CMP;
                        end else begin
                            n_step  = r_step + 4'd1;
                            n_state = S_LOAD;
                        end
                    end else begin
                        n_j = r_j + 3'd1;
                        n_i = '0;
                    end
                end else begin
                    n_i = r_i + 4'd1;
                end
            end
            S_CMP: begin
                o_cmd.div_init = 1'b1;
                n_cnt   = '0;
                n_state = i_sts.less ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (r_cnt == DIV_CNT_W'(QUO_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_i         <= n_i;
            r_j         <= n_j;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign s_tready = (r_state == S_IDLE);
    assign m_tvalid = r_out_valid;

endmodule

@@ sv/ckd_dpath.sv @@
// Datapath of the curvature kink detector: window, long-number engine and divider.
module ckd_dpath import ckd_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                   i_s_tuser,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    output logic                   o_m_tuser
);

    localparam logic [1:0] REL_ZERO = 2'd0;
    localparam logic [1:0] REL_FULL = 2'd1;
    localparam logic [1:0] REL_DIV  = 2'd2;

    function automatic logic [POS_W-1:0] mag33(input logic [POS_W:0] v);
        return v[POS_W] ? POS_W'(-v) : v[POS_W-1:0];
    endfunction

    function automatic logic [2*POS_W:0] mag66(input logic [2*POS_W+1:0] v);
        return v[2*POS_W+1] ? (2*POS_W+1)'(-v) : v[2*POS_W:0];
    endfunction

    // Configuration.
    logic [THR_W-1:0]  r_thresh;
    logic [POS_W-1:0]  r_box_min;
    logic [LEN_W-1:0]  r_box_len;
    logic [TIME_W-1:0] r_ftime;

    // Window of the two held points, entry 0 older.
    logic [1:0][POS_W-1:0] r_win_x, r_win_z;
    logic [1:0][IDX_W-1:0] r_win_idx;
    logic [1:0]            r_held;
    logic                  r_eval;

    // Differences of the current window as magnitude and sign.
    logic [POS_W-1:0] r_a, r_b, r_p, r_q, r_s;
    logic             r_sa, r_sb, r_sp, r_sq, r_ss, r_sm;
    logic [POS_W:0]   r_num;
    logic [IDX_W-1:0] r_mid_idx;
    logic [2*POS_W-1:0] r_ab, r_pb, r_qa;
    logic [2*POS_W:0]   r_d, r_n, r_m;

    // Long-number engine.
    logic [Z_LIMBS-1:0][LIMB_W-1:0] r_x, r_z, r_l;
    logic [Y_LIMBS-1:0][LIMB_W-1:0] r_y, r_k;
    logic [LIMB_W-1:0]              r_c;

    // Divider and result.
    logic [LIMB_W-1:0] r_rem;
    logic [QUO_W-1:0]  r_quo;
    logic [1:0]        r_rel_mode;
    logic [TIME_W-1:0] r_out_time;
    logic [IDX_W-1:0]  r_out_idx;
    logic [REL_W-1:0]  r_out_rel;
    logic              r_out_peak;

    logic [POS_W-1:0]  in_x, in_z;
    logic [IDX_W-1:0]  in_idx;
    logic [1:0]        held_eff;
    logic [POS_W:0]    dx01, dx12, dz01, dz12, dx02, num;
    logic [LIMB_W-1:0] mul_a, mul_b;
    logic [2*LIMB_W-1:0] prod, mac_sum;
    logic [ZI_W-1:0]   zi;
    logic [2*POS_W+1:0] spb, sqa, sum_n, dif_m;
    t_step             desc;
    logic [Z_LIMBS-1:0][LIMB_W-1:0] xv;
    logic [Y_LIMBS-1:0][LIMB_W-1:0] yv;
    logic [THR_W+3:0]  t16;
    logic [LEN_W-1:0]  len;
    logic [LIMB_W-1:0] rem2;
    logic              qbit;
    logic [REL_W-1:0]  rel;

    always_comb begin
        in_x   = i_s_tdata[POS_W-1:0];
        in_z   = i_s_tdata[2*POS_W-1:POS_W];
        in_idx = i_s_tdata[2*POS_W+IDX_W-1:2*POS_W];
        held_eff = i_s_tuser ? 2'd0 : r_held;
        dx01 = {r_win_x[0][POS_W-1], r_win_x[0]} - {r_win_x[1][POS_W-1], r_win_x[1]};
        dx12 = {r_win_x[1][POS_W-1], r_win_x[1]} - {in_x[POS_W-1], in_x};
        dx02 = {r_win_x[0][POS_W-1], r_win_x[0]} - {in_x[POS_W-1], in_x};
        dz01 = {r_win_z[0][POS_W-1], r_win_z[0]} - {r_win_z[1][POS_W-1], r_win_z[1]};
        dz12 = {r_win_z[1][POS_W-1], r_win_z[1]} - {in_z[POS_W-1], in_z};
        num  = {r_win_x[1][POS_W-1], r_win_x[1]} - {r_box_min[POS_W-1], r_box_min};
    end

    // Shared 32x32 multiplier; in the engine it forms z[i+j] + x[i]*y[j] + carry,
    // which cannot exceed 64 bits.
    always_comb begin
        zi = i_cmd.i + ZI_W'(i_cmd.j);
        case (i_cmd.mul_sel)
            MS_AB:   begin mul_a = r_a; mul_b = r_b; end
            MS_PB:   begin mul_a = r_p; mul_b = r_b; end
            MS_QA:   begin mul_a = r_q; mul_b = r_a; end
            default: begin mul_a = r_x[i_cmd.i]; mul_b = r_y[i_cmd.j]; end
        endcase
        prod    = mul_a * mul_b;
        mac_sum = prod + (2*LIMB_W)'(r_z[zi]) + (2*LIMB_W)'(i_cmd.first ? '0 : r_c);
    end

    always_comb begin
        spb   = (r_sp ^ r_sb) ? -{2'b00, r_pb} : {2'b00, r_pb};
        sqa   = (r_sq ^ r_sa) ? -{2'b00, r_qa} : {2'b00, r_qa};
        sum_n = spb + sqa;
        dif_m = spb - sqa;
    end

    always_comb begin
        desc = step_desc(i_cmd.step);
        t16  = {r_thresh, 4'b0000};
        case (desc.xsrc)
            XS_D:    xv = ZB'(r_d);
            XS_N:    xv = ZB'(r_n);
            XS_T16:  xv = ZB'(t16);
            default: xv = r_z;
        endcase
        case (desc.ysrc)
            YS_D:    yv = YB'(r_d);
            YS_N:    yv = YB'(r_n);
            YS_ZLO:  yv = r_z[Y_LIMBS-1:0];
            YS_K:    yv = r_k;
            YS_S:    yv = YB'(r_s);
            YS_T16:  yv = YB'(t16);
            YS_M:    yv = YB'(r_m);
            default: yv = YB'(r_ab);
        endcase
    end

    always_comb begin
        len  = (r_box_len == '0) ? LEN_W'(1) : r_box_len;
        rem2 = {r_rem[LIMB_W-2:0], 1'b0};
        qbit = (rem2 >= LIMB_W'(len));
        case (r_rel_mode)
            REL_FULL: rel = REL_W'(1) << QUO_W;
            REL_DIV:  rel = {1'b0, r_quo};
            default:  rel = '0;
        endcase
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh  <= THR_W'(131072);
            r_box_min <= '0;
            r_box_len <= LEN_W'(65536);
            r_ftime   <= '0;
            r_held    <= '0;
            r_eval    <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_addr)
                    CFG_THRESH:     r_thresh  <= i_cfg_wdata[THR_W-1:0];
                    CFG_BOX_MIN:    r_box_min <= i_cfg_wdata[POS_W-1:0];
                    CFG_BOX_LEN:    r_box_len <= i_cfg_wdata[LEN_W-1:0];
                    CFG_FRAME_TIME: r_ftime   <= i_cfg_wdata[TIME_W-1:0];
                    default:        r_ftime   <= r_ftime;
                endcase
            end
            if (i_cmd.accept) begin
                r_eval <= (held_eff == 2'd2);
                if (held_eff != 2'd2) begin
                    r_held <= held_eff + 2'd1;
                end
            end
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a  <= mag33(dx01);  r_sa <= dx01[POS_W];
            r_b  <= mag33(dx12);  r_sb <= dx12[POS_W];
            r_s  <= mag33(dx02);  r_ss <= dx02[POS_W];
            r_p  <= mag33(dz01);  r_sp <= dz01[POS_W];
            r_q  <= mag33(dz12);  r_sq <= dz12[POS_W];
            r_num     <= num;
            r_mid_idx <= r_win_idx[1];
            if (held_eff == 2'd2) begin
                r_win_x[0]   <= r_win_x[1];
                r_win_z[0]   <= r_win_z[1];
                r_win_idx[0] <= r_win_idx[1];
                r_win_x[1]   <= in_x;
                r_win_z[1]   <= in_z;
                r_win_idx[1] <= in_idx;
            end else begin
                r_win_x[held_eff[0]]   <= in_x;
                r_win_z[held_eff[0]]   <= in_z;
                r_win_idx[held_eff[0]] <= in_idx;
            end
        end
        if (i_cmd.prep_mul) begin
            case (i_cmd.mul_sel)
                MS_AB:   r_ab <= prod;
                MS_PB:   r_pb <= prod;
                default: r_qa <= prod;
            endcase
        end
        if (i_cmd.combine) begin
            r_d  <= {r_ab, 1'b0};
            r_n  <= mag66(sum_n);
            r_m  <= mag66(dif_m);
            r_sm <= dif_m[2*POS_W+1];
        end
        if (i_cmd.load) begin
            r_x <= xv;
            r_y <= yv;
            if (desc.save_k) r_k <= r_z[Y_LIMBS-1:0];
            if (desc.save_l) r_l <= r_z;
            if (desc.clear)  r_z <= '0;
        end else if (i_cmd.mac) begin
            r_z[zi] <= mac_sum[LIMB_W-1:0];
            r_c     <= mac_sum[2*LIMB_W-1:LIMB_W];
        end
        if (i_cmd.div_init) begin
            r_rem <= r_num[LIMB_W-1:0];
            r_quo <= '0;
            if (r_num[POS_W] || r_num == '0) begin
                r_rel_mode <= REL_ZERO;
            end else if (r_num >= (POS_W+1)'(len)) begin
                r_rel_mode <= REL_FULL;
            end else begin
                r_rel_mode <= REL_DIV;
            end
        end else if (i_cmd.div_step) begin
            r_rem <= qbit ? rem2 - LIMB_W'(len) : rem2;
            r_quo <= {r_quo[QUO_W-2:0], qbit};
        end
        if (i_cmd.load_out) begin
            r_out_time <= r_ftime;
            r_out_idx  <= r_mid_idx;
            r_out_rel  <= rel;
            // Peak when the sign of AB*S differs from the sign of M.
            r_out_peak <= r_sa ^ r_sb ^ r_ss ^ r_sm;
        end
    end

    always_comb begin
        o_sts.eval   = r_eval;
        o_sts.degen  = (r_a == '0) || (r_b == '0) || (r_s == '0);
        o_sts.m_zero = (r_m == '0);
        o_sts.less   = (r_l < r_z);
    end

    assign o_m_tdata = OUT_TDATA_W'({r_out_rel, r_out_idx, r_out_time});
    assign o_m_tuser = r_out_peak;

endmodule
